[src/hed_pkg.sv]
// ----------------------------------------------------------------------------
// hed_pkg
// Character codes and the entity name table used by the scan side (hed_front).
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam logic [7:0] AMP_CHAR  = 8'h26;
    localparam logic [7:0] SEMI_CHAR = 8'h3B;

    localparam int NUM_ENTITIES = 6;
    localparam int ENT_MAX_LEN  = 5;

    typedef struct packed {
        logic [2:0]                  len;
        logic [ENT_MAX_LEN-1:0][7:0] name;   // name[0] is the first character
        logic [7:0]                  ch;
    } entity_t;

    localparam entity_t ENTITIES [NUM_ENTITIES] = '{
        '{len: 3'd3, name: {8'h00, 8'h00, "p", "m", "a"}, ch: "&"},
        '{len: 3'd2, name: {8'h00, 8'h00, 8'h00, "t", "g"}, ch: ">"},
        '{len: 3'd2, name: {8'h00, 8'h00, 8'h00, "t", "l"}, ch: "<"},
        '{len: 3'd4, name: {8'h00, "p", "s", "b", "n"}, ch: " "},
        '{len: 3'd4, name: {8'h00, "s", "u", "l", "p"}, ch: "+"},
        '{len: 3'd5, name: {"t", "s", "e", "u", "q"}, ch: "?"}
    };

endpackage

[src/hed_front.sv]
// ----------------------------------------------------------------------------
// hed_front
// Input side: tracks the entity scan state and turns each input word into
// at most one queue entry holding the words to send.
// ----------------------------------------------------------------------------
module hed_front #(
    parameter int MAX_NAME_LEN = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                q_full,
    output logic                                push,
    output logic [(MAX_NAME_LEN+2)*8-1:0]       push_bytes,
    output logic [$clog2(MAX_NAME_LEN+2)-1:0]   push_lidx,
    output logic                                push_last
);
    import hed_pkg::*;

    localparam int CW = $clog2(MAX_NAME_LEN + 1);
    localparam int IW = $clog2(MAX_NAME_LEN + 2);
    localparam int NB = MAX_NAME_LEN + 2;

    logic          in_ent_reg, in_ent_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    name_reg  [MAX_NAME_LEN];
    logic [7:0]    name_next [MAX_NAME_LEN];
    logic [7:0]    tmp       [MAX_NAME_LEN+1];
    logic [7:0]    win       [ENT_MAX_LEN];
    logic [7:0]    vec       [NB];
    logic          hit;
    logic [7:0]    hit_char;
    logic [IW-1:0] amp_pos;
    logic          accept;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_last     = s_axis_tlast;

    genvar g;
    generate
        for (g = 0; g < MAX_NAME_LEN; g++)
        begin : g_tmp
            assign tmp[g] = name_reg[g];
        end
        assign tmp[MAX_NAME_LEN] = s_axis_tdata;

        for (g = 0; g < ENT_MAX_LEN; g++)
        begin : g_win
            if (g < MAX_NAME_LEN)
            begin : g_have
                assign win[g] = name_reg[g];
            end
            else
            begin : g_pad
                assign win[g] = 8'h00;
            end
        end

        for (g = 0; g < NB; g++)
        begin : g_pack
            assign push_bytes[g*8 +: 8] = vec[g];
        end
    endgenerate

    // name table lookup
    always_comb
    begin
        logic match;
        hit      = 1'b0;
        hit_char = AMP_CHAR;
        for (int t = 0; t < NUM_ENTITIES; t++)
        begin
            match = (int'(cnt_reg) == int'(ENTITIES[t].len));
            for (int i = 0; i < ENT_MAX_LEN; i++)
            begin
                if (i < int'(ENTITIES[t].len) && win[i] != ENTITIES[t].name[i])
                    match = 1'b0;
            end
            if (match && !hit)
            begin
                hit      = 1'b1;
                hit_char = ENTITIES[t].ch;
            end
        end
    end

    // first ampersand among the held name bytes and the new byte
    always_comb
    begin
        amp_pos = IW'(MAX_NAME_LEN + 1);
        for (int i = MAX_NAME_LEN; i >= 0; i--)
        begin
            if (tmp[i] == AMP_CHAR)
                amp_pos = IW'(i);
        end
    end

    always_comb
    begin
        in_ent_next = in_ent_reg;
        cnt_next    = cnt_reg;
        name_next   = name_reg;
        push        = 1'b0;
        push_lidx   = '0;
        vec[0]      = AMP_CHAR;
        // raw run: held bytes, then the new byte
        for (int j = 1; j < NB; j++)
            vec[j] = (j - 1 < int'(cnt_reg)) ? tmp[j-1] : s_axis_tdata;

        if (accept)
        begin
            if (!in_ent_reg)
            begin
                cnt_next = '0;
                if (s_axis_tdata == AMP_CHAR)
                begin
                    push        = s_axis_tlast;
                    in_ent_next = !s_axis_tlast;
                end
                else
                begin
                    push   = 1'b1;
                    vec[0] = s_axis_tdata;
                end
            end
            else if (s_axis_tdata == SEMI_CHAR)
            begin
                push        = 1'b1;
                in_ent_next = 1'b0;
                cnt_next    = '0;
                if (hit)
                    vec[0] = hit_char;
                else
                    push_lidx = IW'(int'(cnt_reg) + 1);
            end
            else if (int'(cnt_reg) < MAX_NAME_LEN)
            begin
                for (int i = 0; i < MAX_NAME_LEN; i++)
                begin
                    if (i == int'(cnt_reg))
                        name_next[i] = s_axis_tdata;
                end
                if (s_axis_tlast)
                begin
                    push        = 1'b1;
                    push_lidx   = IW'(int'(cnt_reg) + 1);
                    in_ent_next = 1'b0;
                    cnt_next    = '0;
                end
                else
                begin
                    cnt_next = CW'(int'(cnt_reg) + 1);
                end
            end
            else
            begin
                // name too long: send up to the next ampersand, restart after it
                push = 1'b1;
                if (s_axis_tlast)
                begin
                    push_lidx   = IW'(MAX_NAME_LEN + 1);
                    in_ent_next = 1'b0;
                    cnt_next    = '0;
                end
                else
                begin
                    push_lidx = amp_pos;
                    if (int'(amp_pos) <= MAX_NAME_LEN)
                    begin
                        in_ent_next = 1'b1;
                        cnt_next    = CW'(MAX_NAME_LEN - int'(amp_pos));
                        for (int i = 0; i < MAX_NAME_LEN; i++)
                        begin
                            for (int k = 0; k <= MAX_NAME_LEN; k++)
                            begin
                                if (k == int'(amp_pos) + 1 + i)
                                    name_next[i] = tmp[k];
                            end
                        end
                    end
                    else
                    begin
                        in_ent_next = 1'b0;
                        cnt_next    = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ent_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            in_ent_reg <= in_ent_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_reg <= name_next;
    end

endmodule

[src/hed_fifo.sv]
// ----------------------------------------------------------------------------
// hed_fifo
// Small first-in first-out queue between the scan side and the output side.
// ----------------------------------------------------------------------------
module hed_fifo #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

[src/hed_back.sv]
// ----------------------------------------------------------------------------
// hed_back
// Output side: walks through the words of the queue head one per cycle, while
// the output is not stalled, into a registered output word.
// ----------------------------------------------------------------------------
module hed_back #(
    parameter int MAX_NAME_LEN = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  logic [(MAX_NAME_LEN+2)*8-1:0]       q_bytes,
    input  logic [$clog2(MAX_NAME_LEN+2)-1:0]   q_lidx,
    input  logic                                q_last,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,
    output logic                                m_axis_tlast
);
    localparam int IW = $clog2(MAX_NAME_LEN + 2);
    localparam int NB = MAX_NAME_LEN + 2;

    logic [7:0]    words [NB];
    logic [IW-1:0] idx_reg, idx_next;
    logic          valid_reg, valid_next;
    logic [7:0]    data_reg, data_next;
    logic          last_reg, last_next;
    logic          load, at_end;

    genvar g;
    generate
        for (g = 0; g < NB; g++)
        begin : g_unpack
            assign words[g] = q_bytes[g*8 +: 8];
        end
    endgenerate

    assign load   = q_valid && (!valid_reg || m_axis_tready);
    assign at_end = (idx_reg == q_lidx);
    assign q_pop  = load && at_end;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = words[idx_reg];
            last_next  = q_last && at_end;
            idx_next   = at_end ? '0 : idx_reg + 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

[src/html_entity_decoder.sv]
// ----------------------------------------------------------------------------
// html_entity_decoder
// Stream decoder for the entities amp, gt, lt, nbsp, plus and quest.
//
//  channel  | dir | tdata           | tlast
//  ---------+-----+-----------------+----------------------
//  s_axis   | in  | [7:0] text byte | last byte of text
//  m_axis   | out | [7:0] text byte | last decoded byte
//
// The input takes one word per cycle while the queue has room; each input
// word becomes zero or one queue entry of 1 to MAX_NAME_LEN+2 output words.
// The output side sends one word per cycle while m_axis_tready is high, so
// the byte-serial output port sets the rate.
// Reset clears the scan state, the queue and the output valid flag.
// A stalled output fills the queue and then holds s_axis_tready low.
// ----------------------------------------------------------------------------
module html_entity_decoder #(
    parameter int MAX_NAME_LEN = 5,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast
);
    localparam int IW = $clog2(MAX_NAME_LEN + 2);
    localparam int BW = (MAX_NAME_LEN + 2) * 8;
    localparam int EW = BW + IW + 1;

    logic          q_full, push, push_last, q_pop, q_valid;
    logic [BW-1:0] push_bytes;
    logic [IW-1:0] push_lidx;
    logic [EW-1:0] q_wr, q_rd;

    hed_front #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .push          (push),
        .push_bytes    (push_bytes),
        .push_lidx     (push_lidx),
        .push_last     (push_last)
    );

    assign q_wr = {push_last, push_lidx, push_bytes};

    hed_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (q_wr),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd)
    );

    hed_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_bytes       (q_rd[BW-1:0]),
        .q_lidx        (q_rd[BW +: IW]),
        .q_last        (q_rd[EW-1]),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[src/hed_assert.sv]
// ----------------------------------------------------------------------------
// hed_assert
// Port-level checks for the entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hed_assert (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // a full queue means the output side already holds a word
    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output word");

    // the output valid flag is held low by reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

endmodule

bind html_entity_decoder hed_assert u_hed_assert (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
